// ----- rtl/gamepad_event_autorepeat_top_defines.svh -----
// Assertion macros shared by the gamepad event block.
`ifndef GAMEPAD_EVENT_AUTOREPEAT_TOP_DEFINES_SVH
`define GAMEPAD_EVENT_AUTOREPEAT_TOP_DEFINES_SVH

// Implication checked at every rising clock edge outside reset.
`define GEA_ASSERT_IMPLIES(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define GEA_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// ----- rtl/gea_pkg.sv -----
// Types and constants of the gamepad event block.
package gea_pkg;

	localparam int PAD_COUNT_DEF    = 4;
	localparam int BUTTON_COUNT_DEF = 14;
	localparam int AXIS_COUNT       = 6;
	localparam int COUNT_W          = 7;
	localparam int TRIG_W           = 8;
	localparam int THUMB_W          = 16;
	localparam int DZ_W             = 15;
	localparam int VALUE_W          = 18;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 15;

	localparam logic [CFG_INDEX_W-1:0] REG_REPEAT_DELAY      = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_TRIGGER_THRESHOLD = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_LEFT_DEADZONE     = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_RIGHT_DEADZONE    = 2'd3;

	localparam logic [COUNT_W-1:0] REPEAT_DELAY_RST      = 7'd60;
	localparam logic [TRIG_W-1:0]  TRIGGER_THRESHOLD_RST = 8'd30;
	localparam logic [DZ_W-1:0]    LEFT_DEADZONE_RST     = 15'd7849;
	localparam logic [DZ_W-1:0]    RIGHT_DEADZONE_RST    = 15'd8689;

	typedef enum logic [1:0] {
		EV_DOWN   = 2'd0,
		EV_REPEAT = 2'd1,
		EV_UP     = 2'd2,
		EV_ANALOG = 2'd3
	} event_kind_t;

	// Bit of the button word that belongs to each button number.
	localparam logic [15:0] BUTTON_MASK [16] = '{
		16'h0001, 16'h0002, 16'h0004, 16'h0008, 16'h8000, 16'h1000, 16'h4000, 16'h2000,
		16'h0080, 16'h0040, 16'h0200, 16'h0100, 16'h0010, 16'h0020, 16'h0400, 16'h0800
	};

	// Trigger to Q1.16: v * 65536 / 255 rounded, which is v * 257 plus one carry.
	function automatic logic signed [VALUE_W-1:0] norm_trigger(input logic [TRIG_W-1:0] v);
		logic [VALUE_W-1:0] prod;
		logic [9:0]         rem;
		begin
			prod = {2'b00, v, 8'd0} + {10'd0, v};
			rem  = {2'b00, v} + 10'd127;
			norm_trigger = signed'(prod + ((rem >= 10'd255) ? 18'd1 : 18'd0));
		end
	endfunction

	// Thumb to Q1.16: negative values double, positive ones scale by 65536 / 32767.
	function automatic logic signed [VALUE_W-1:0] norm_thumb(input logic signed [THUMB_W-1:0] v);
		logic [VALUE_W-1:0] twice;
		logic [VALUE_W-1:0] rem;
		begin
			twice = {v[THUMB_W-1], v, 1'b0};
			rem   = {1'b0, v, 1'b0} + 18'd16383;
			if (v[THUMB_W-1]) begin
				norm_thumb = signed'(twice);
			end else begin
				norm_thumb = signed'(twice + ((rem >= 18'd32767) ? 18'd1 : 18'd0)
					+ ((rem >= 18'd65534) ? 18'd1 : 18'd0));
			end
		end
	endfunction

endpackage

// ----- rtl/gamepad_event_autorepeat_top.sv -----
// Top level of the gamepad event block: poll decoding, auto-repeat state and event output.

// One poll is accepted per cycle while in_ready is high and passes through a single input
// register, where the per-pad button and analog state is read, updated and written back
// in the same cycle, so polls for the same pad may follow each other directly. The events
// of a poll are placed in an event buffer and leave through the output register at one
// event per cycle while out_ready allows, buttons first in button order, then the axes RT,
// LT, RX, RY, LX, LY. A poll raises up to the button count plus six events. The input
// waits while the buffer holds more than the event being sent or cannot send it. A poll
// passes the input register and the event buffer on its way to the output register. All
// per-pad state is cleared by reset; no clearing pass is needed.
`include "gamepad_event_autorepeat_top_defines.svh"

module gamepad_event_autorepeat_top #(
	parameter int PAD_COUNT    = gea_pkg::PAD_COUNT_DEF,
	parameter int BUTTON_COUNT = gea_pkg::BUTTON_COUNT_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          cfg_write,
	input  logic [gea_pkg::CFG_INDEX_W-1:0]               cfg_index,
	input  logic [gea_pkg::CFG_DATA_W-1:0]                cfg_data,
	input  logic                                          in_valid,
	output logic                                          in_ready,
	input  logic [1:0]                                    pad_index,
	input  logic [15:0]                                   button_word,
	input  logic [gea_pkg::TRIG_W-1:0]                    left_trigger,
	input  logic [gea_pkg::TRIG_W-1:0]                    right_trigger,
	input  logic signed [gea_pkg::THUMB_W-1:0]            left_x,
	input  logic signed [gea_pkg::THUMB_W-1:0]            left_y,
	input  logic signed [gea_pkg::THUMB_W-1:0]            right_x,
	input  logic signed [gea_pkg::THUMB_W-1:0]            right_y,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic [1:0]                                    event_kind,
	output logic [1:0]                                    event_pad,
	output logic [3:0]                                    event_source,
	output logic signed [gea_pkg::VALUE_W-1:0]            analog_value,
	output logic                                          last_event
);

	localparam int AxisCount = gea_pkg::AXIS_COUNT;
	localparam int EvCount   = BUTTON_COUNT + AxisCount;
	localparam int RowW      = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;
	localparam int CountW    = gea_pkg::COUNT_W;
	localparam int TrigW     = gea_pkg::TRIG_W;
	localparam int ThumbW    = gea_pkg::THUMB_W;
	localparam int DzW       = gea_pkg::DZ_W;
	localparam int ValueW    = gea_pkg::VALUE_W;

	// Configuration registers.
	logic [CountW-1:0] repeat_delay_q;
	logic [TrigW-1:0]  trigger_threshold_q;
	logic [DzW-1:0]    left_deadzone_q;
	logic [DzW-1:0]    right_deadzone_q;

	// Per-pad state, one row per pad.
	logic [BUTTON_COUNT-1:0] pressed_q [PAD_COUNT];
	logic [CountW-1:0]       count_q   [PAD_COUNT][BUTTON_COUNT];
	logic [TrigW-1:0]        trig_q    [PAD_COUNT][2];
	logic [ThumbW-1:0]       thumb_q   [PAD_COUNT][4];

	// Input register.
	logic                     valid_s1;
	logic [1:0]               pad_s1;
	logic [15:0]              buttons_s1;
	logic [TrigW-1:0]         ltrig_s1;
	logic [TrigW-1:0]         rtrig_s1;
	logic signed [ThumbW-1:0] lx_s1;
	logic signed [ThumbW-1:0] ly_s1;
	logic signed [ThumbW-1:0] rx_s1;
	logic signed [ThumbW-1:0] ry_s1;

	// Event buffer.
	logic [EvCount-1:0]       pend_s2;
	logic [1:0]               pad_s2;
	gea_pkg::event_kind_t     btn_kind_s2 [BUTTON_COUNT];
	logic signed [ValueW-1:0] ana_s2      [AxisCount];

	// Output register.
	logic                     out_valid_q;
	gea_pkg::event_kind_t     kind_q;
	logic [1:0]               pad_q;
	logic [3:0]               source_q;
	logic signed [ValueW-1:0] value_q;
	logic                     last_q;

	// Stage one combinational results.
	logic [4:0]               pad_ext;
	logic                     pad_ok;
	logic [RowW-1:0]          row;
	logic [BUTTON_COUNT-1:0]  new_pressed;
	logic [CountW-1:0]        new_count [BUTTON_COUNT];
	gea_pkg::event_kind_t     new_kind  [BUTTON_COUNT];
	logic [TrigW-1:0]         trig_in   [2];
	logic signed [ThumbW-1:0] thumb_in  [4];
	logic [DzW-1:0]           dz        [4];
	logic [EvCount-1:0]       ev_mask;
	logic signed [ValueW-1:0] ana_val   [AxisCount];
	logic [CountW-1:0]        cnt_inc;
	logic                     btn_now;
	logic                     btn_prev;
	logic [ThumbW:0]          mag;

	// Emitter combinational results.
	logic [EvCount-1:0]       lowbit;
	logic [EvCount-1:0]       rest;
	gea_pkg::event_kind_t     emit_kind;
	logic [3:0]               emit_source;
	logic signed [ValueW-1:0] emit_value;

	logic out_load;
	logic buf_free;
	logic s1_adv;

	assign out_load = (pend_s2 != '0) && (!out_valid_q || out_ready);
	assign buf_free = (pend_s2 == '0) || (out_load && (rest == '0));
	assign s1_adv   = valid_s1 && buf_free;
	assign in_ready = !valid_s1 || s1_adv;

	assign pad_ext = {3'b000, pad_s1};
	assign pad_ok  = (32'(pad_ext) < PAD_COUNT);
	assign row     = RowW'(pad_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_delay_q      <= gea_pkg::REPEAT_DELAY_RST;
			trigger_threshold_q <= gea_pkg::TRIGGER_THRESHOLD_RST;
			left_deadzone_q     <= gea_pkg::LEFT_DEADZONE_RST;
			right_deadzone_q    <= gea_pkg::RIGHT_DEADZONE_RST;
		end else if (cfg_write) begin
			case (cfg_index)
				gea_pkg::REG_REPEAT_DELAY:      repeat_delay_q      <= cfg_data[CountW-1:0];
				gea_pkg::REG_TRIGGER_THRESHOLD: trigger_threshold_q <= cfg_data[TrigW-1:0];
				gea_pkg::REG_LEFT_DEADZONE:     left_deadzone_q     <= cfg_data[DzW-1:0];
				gea_pkg::REG_RIGHT_DEADZONE:    right_deadzone_q    <= cfg_data[DzW-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pad_s1     <= pad_index;
			buttons_s1 <= button_word;
			ltrig_s1   <= left_trigger;
			rtrig_s1   <= right_trigger;
			lx_s1      <= left_x;
			ly_s1      <= left_y;
			rx_s1      <= right_x;
			ry_s1      <= right_y;
		end
	end

	always_comb begin
		trig_in[0]  = rtrig_s1;
		trig_in[1]  = ltrig_s1;
		thumb_in[0] = rx_s1;
		thumb_in[1] = ry_s1;
		thumb_in[2] = lx_s1;
		thumb_in[3] = ly_s1;
		dz[0]       = right_deadzone_q;
		dz[1]       = right_deadzone_q;
		dz[2]       = left_deadzone_q;
		dz[3]       = left_deadzone_q;
		ev_mask     = '0;
		cnt_inc     = '0;
		btn_now     = 1'b0;
		btn_prev    = 1'b0;
		mag         = '0;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			btn_now        = |(buttons_s1 & gea_pkg::BUTTON_MASK[b]);
			btn_prev       = pressed_q[row][b];
			cnt_inc        = count_q[row][b] + CountW'(1);
			new_pressed[b] = btn_now;
			new_count[b]   = count_q[row][b];
			new_kind[b]    = gea_pkg::EV_DOWN;
			if (btn_now && btn_prev) begin
				new_count[b] = cnt_inc;
				new_kind[b]  = gea_pkg::EV_REPEAT;
				if (cnt_inc >= repeat_delay_q) begin
					ev_mask[b]   = 1'b1;
					new_count[b] = repeat_delay_q;
				end
			end else if (btn_now) begin
				ev_mask[b]   = 1'b1;
				new_count[b] = CountW'(1);
			end else if (btn_prev) begin
				ev_mask[b]   = 1'b1;
				new_count[b] = '0;
				new_kind[b]  = gea_pkg::EV_UP;
			end
		end
		for (int a = 0; a < 2; a++) begin
			ana_val[a] = gea_pkg::norm_trigger(trig_in[a]);
			if ((trig_in[a] != trig_q[row][a]) || (trig_in[a] > trigger_threshold_q)) begin
				ev_mask[BUTTON_COUNT+a] = 1'b1;
			end
		end
		for (int a = 0; a < 4; a++) begin
			ana_val[a+2] = gea_pkg::norm_thumb(thumb_in[a]);
			mag = thumb_in[a][ThumbW-1] ? ((ThumbW+1)'(0) - {1'b1, thumb_in[a]})
				: {1'b0, thumb_in[a]};
			if ((thumb_in[a] != signed'(thumb_q[row][a])) || (mag > {2'b00, dz[a]})) begin
				ev_mask[BUTTON_COUNT+2+a] = 1'b1;
			end
		end
		if (!pad_ok) begin
			ev_mask = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < PAD_COUNT; p++) begin
				pressed_q[p] <= '0;
				for (int b = 0; b < BUTTON_COUNT; b++) begin
					count_q[p][b] <= '0;
				end
				trig_q[p][0] <= '0;
				trig_q[p][1] <= '0;
				for (int a = 0; a < 4; a++) begin
					thumb_q[p][a] <= '0;
				end
			end
		end else if (s1_adv && pad_ok) begin
			pressed_q[row] <= new_pressed;
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				count_q[row][b] <= new_count[b];
			end
			trig_q[row][0] <= trig_in[0];
			trig_q[row][1] <= trig_in[1];
			for (int a = 0; a < 4; a++) begin
				thumb_q[row][a] <= thumb_in[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s2 <= '0;
		end else if (s1_adv) begin
			pend_s2 <= ev_mask;
		end else if (out_load) begin
			pend_s2 <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pad_s2 <= pad_s1;
			for (int b = 0; b < BUTTON_COUNT; b++) begin
				btn_kind_s2[b] <= new_kind[b];
			end
			for (int a = 0; a < AxisCount; a++) begin
				ana_s2[a] <= ana_val[a];
			end
		end
	end

	always_comb begin
		lowbit      = pend_s2 & (~pend_s2 + EvCount'(1));
		rest        = pend_s2 & ~lowbit;
		emit_kind   = gea_pkg::EV_ANALOG;
		emit_source = '0;
		emit_value  = '0;
		for (int b = 0; b < BUTTON_COUNT; b++) begin
			if (lowbit[b]) begin
				emit_kind   = btn_kind_s2[b];
				emit_source = 4'(b);
			end
		end
		for (int a = 0; a < AxisCount; a++) begin
			if (lowbit[BUTTON_COUNT+a]) begin
				emit_kind   = gea_pkg::EV_ANALOG;
				emit_source = 4'(a);
				emit_value  = ana_s2[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= (pend_s2 != '0);
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			kind_q   <= emit_kind;
			pad_q    <= pad_s2;
			source_q <= emit_source;
			value_q  <= emit_value;
			last_q   <= (rest == '0);
		end
	end

	assign out_valid    = out_valid_q;
	assign event_kind   = kind_q;
	assign event_pad    = pad_q;
	assign event_source = source_q;
	assign analog_value = value_q;
	assign last_event   = last_q;

	`GEA_ASSERT_IMPLIES(a_more_pending, out_valid_q && !last_q, pend_s2 != '0, "non-final beat shown with an empty event buffer")
	`GEA_ASSERT_IMPLIES(a_stall_busy, valid_s1 && ($countones(pend_s2) > 1), !in_ready, "poll taken while the event buffer is busy")
	`GEA_ASSERT_NEXT(a_state_in_step, s1_adv && pad_ok, pressed_q[$past(row)] == $past(new_pressed), "button state not written back")

endmodule
